/* rtl/key_value_list_tokenizer_core_macros.svh */
// Assertion macros for the key-value list tokenizer core.
`ifndef KEY_VALUE_LIST_TOKENIZER_CORE_MACROS_SVH
`define KEY_VALUE_LIST_TOKENIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define KVT_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define KVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define KVT_ASSERT_ALWAYS(lbl, expr, msg)
`define KVT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/kvt_pkg.sv */
// Shared types, character constants and helpers of the key-value list tokenizer.
package kvt_pkg;

    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_EQ   = 8'h3D;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    typedef enum logic [1:0] {
        ROLE_SKIP    = 2'd0,
        ROLE_KEY     = 2'd1,
        ROLE_VALUE   = 2'd2,
        ROLE_KEY_END = 2'd3
    } t_role;

    typedef struct packed {
        logic in_value;
        logic prev_semicolon;
        logic key_nonempty;
        logic value_nonempty;
        logic has_pair;
        logic stopped;
        logic invalid;
    } t_kvt_state;

    typedef struct packed {
        logic [7:0] echo_byte;
        t_role      role;
        logic       pair_closed;
        logic       final_pair_closed;
        logic       failed;
        logic       verdict_valid;
        logic       end_item;
    } t_kvt_result;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

/* rtl/kvt_if.sv */
// Valid/ready stream interfaces for the tokenizer input and result channels.
interface kvt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface kvt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] echo_byte;
    logic [1:0] role;
    logic       pair_closed;
    logic       final_pair_closed;
    logic       failed;
    logic       verdict_valid;
    logic       end_item;

    modport source (output valid, output echo_byte, output role, output pair_closed,
                    output final_pair_closed, output failed, output verdict_valid,
                    output end_item, input ready);
    modport sink   (input valid, input echo_byte, input role, input pair_closed,
                    input final_pair_closed, input failed, input verdict_valid,
                    input end_item, output ready);
endinterface

/* rtl/kvt_step.sv */
// Per-byte next-state and result logic of the tokenizer.
module kvt_step import kvt_pkg::*; (
    input  t_kvt_state  i_state,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output t_kvt_state  o_state,
    output t_kvt_result o_result
);

    t_kvt_state st;
    t_role      role;
    logic       closed;
    logic       final_closed;
    logic       verdict;
    logic       key_side;
    logic       consumed;
    logic       semi;

    assign semi = (i_byte == CHAR_SEMI);

    always_comb begin
        st           = i_state;
        role         = ROLE_SKIP;
        closed       = 1'b0;
        final_closed = 1'b0;
        verdict      = 1'b0;
        key_side     = 1'b0;
        consumed     = 1'b0;

        if (!st.stopped && !st.invalid) begin
            key_side = !st.in_value;
            if (st.in_value) begin
                if (semi && !st.prev_semicolon) begin
                    st.prev_semicolon = 1'b1;
                    consumed          = 1'b1;
                end else if (!semi && st.prev_semicolon) begin
                    if (!st.value_nonempty) begin
                        st.invalid = 1'b1;
                        consumed   = 1'b1;
                    end else begin
                        // byte after the closing ';' ends the pair, then counts as key input
                        st.has_pair       = 1'b1;
                        closed            = 1'b1;
                        st.key_nonempty   = 1'b0;
                        st.value_nonempty = 1'b0;
                        st.in_value       = 1'b0;
                        key_side          = 1'b1;
                    end
                end else begin
                    st.value_nonempty = 1'b1;
                    role              = ROLE_VALUE;
                end
            end

            if (!consumed && key_side) begin
                if (i_byte == CHAR_EQ) begin
                    if (!st.key_nonempty) begin
                        st.invalid = 1'b1;
                    end else begin
                        st.in_value = 1'b1;
                        role        = ROLE_KEY_END;
                    end
                end else if (is_alnum(i_byte)) begin
                    st.key_nonempty = 1'b1;
                    role            = ROLE_KEY;
                end else if (i_byte == CHAR_NUL && !st.key_nonempty && st.has_pair) begin
                    st.stopped = 1'b1;
                end else if (!st.prev_semicolon || st.key_nonempty) begin
                    st.invalid = 1'b1;
                end
            end

            if (!consumed && !st.invalid && !st.stopped) begin
                st.prev_semicolon = semi;
            end
            if (st.invalid) begin
                role = ROLE_SKIP;
            end
        end

        if (i_last) begin
            if (st.invalid) begin
                verdict = 1'b0;
            end else if (st.stopped) begin
                verdict = 1'b1;
            end else if (st.in_value) begin
                verdict      = st.value_nonempty;
                final_closed = st.value_nonempty;
            end else begin
                verdict = !st.key_nonempty;
            end
        end
    end

    // a new buffer begins after the last byte
    assign o_state = i_last ? '0 : st;

    assign o_result.echo_byte         = i_byte;
    assign o_result.role              = role;
    assign o_result.pair_closed       = closed;
    assign o_result.final_pair_closed = final_closed;
    assign o_result.failed            = st.invalid;
    assign o_result.verdict_valid     = verdict;
    assign o_result.end_item          = i_last;

endmodule

/* rtl/key_value_list_tokenizer_core.sv */
// Key-value list tokenizer: takes one byte per cycle unless the result channel stalls, one result
// item per byte, passing through the input register, then the result register; the byte-to-byte flag
// update is one step of logic, which sets the rate at one item per clock when not stalled.
`include "key_value_list_tokenizer_core_macros.svh"

module key_value_list_tokenizer_core import kvt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    kvt_in_if.sink           i_in,
    kvt_out_if.source        o_out
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    t_kvt_state  r_state;
    logic        r_out_valid;
    t_kvt_result r_out;

    t_kvt_state  n_state;
    t_kvt_result n_out;
    logic        advance;
    logic        step_fire;

    assign advance   = !r_out_valid || o_out.ready;
    assign step_fire = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    kvt_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step_fire) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last;
        end
        if (step_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.echo_byte         = r_out.echo_byte;
    assign o_out.role              = r_out.role;
    assign o_out.pair_closed       = r_out.pair_closed;
    assign o_out.final_pair_closed = r_out.final_pair_closed;
    assign o_out.failed            = r_out.failed;
    assign o_out.verdict_valid     = r_out.verdict_valid;
    assign o_out.end_item          = r_out.end_item;

    `KVT_ASSERT_ALWAYS(a_verdict_on_end,
        !(o_out.valid && o_out.verdict_valid && !o_out.end_item),
        "verdict outside last item")
    `KVT_ASSERT_ALWAYS(a_failed_role_skip,
        !(o_out.valid && o_out.failed && o_out.role != ROLE_SKIP),
        "role on failed item")
    `KVT_ASSERT_NEXT(a_state_clear_after_last, step_fire && r_in_last, r_state == '0,
        "state kept after last item")
    `KVT_ASSERT_NEXT(a_invalid_sticks, step_fire && !r_in_last && n_out.failed,
        r_state.invalid, "invalid flag lost")

endmodule
